>>> design/sspg_pkg.sv
// Package: widths, operation codes, register map and config type for the step/dir generator.
`default_nettype none
package sspg_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 32;
  localparam int unsigned DELAY_WIDTH_DEF    = 16;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STEP_DELAY_W = 16;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 4;

  localparam logic [STEP_DELAY_W-1:0] STEP_DELAY_RST = 16'd100;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_MOVE_ABS = 2'd1,
    OP_MOVE_REL = 2'd2,
    OP_SET_POS  = 2'd3
  } op_e;

  localparam logic [1:0] REG_STEP_DELAY   = 2'd0;
  localparam logic [1:0] REG_HOME_DIR     = 2'd1;
  localparam logic [1:0] REG_REVERSE_DIR  = 2'd2;

  typedef struct packed {
    logic [STEP_DELAY_W-1:0] step_delay;
    logic                    home_dir_high;
    logic                    reverse_direction;
  } cfg_t;

endpackage
`default_nettype wire

>>> design/sspg_if.sv
// Stream interfaces for command/tick beats and result beats.
`default_nettype none
interface sspg_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [sspg_pkg::VALUE_W-1:0] value;
  logic                         limit_active;

  modport source (output valid, operation, value, limit_active, input ready);
  modport sink   (input valid, operation, value, limit_active, output ready);
endinterface

interface sspg_out_if;
  logic                         valid;
  logic                         ready;
  logic                         step_issued;
  logic                         direction_level;
  logic signed [sspg_pkg::VALUE_W-1:0] position;
  logic                         moving;
  logic                         on_target;
  logic                         limit_stop;

  modport source (output valid, step_issued, direction_level, position, moving, on_target,
                  limit_stop, input ready);
  modport sink   (input valid, step_issued, direction_level, position, moving, on_target,
                  limit_stop, output ready);
endinterface
`default_nettype wire

>>> design/stepper_step_dir_position_generator_top.sv
// Top level of the stepper step/dir position generator.
// An accepted beat passes through the input register and then the result register.
// Throughput: one beat per cycle while the output is not stalled; position, target and
// count update in the single stage between the input register and the result register.
// Reset: rst_ni is asynchronous, active low; valid flags, state and configuration take
// their reset values at once, with no clearing pass; beat data registers are not reset.
`default_nettype none
module stepper_step_dir_position_generator_top #(
  parameter int unsigned POSITION_WIDTH = sspg_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned DELAY_WIDTH    = sspg_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  sspg_in_if.sink                              in_ch,
  sspg_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sspg_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [sspg_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [sspg_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  sspg_pkg::cfg_t cfg;

  sspg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sspg_core #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .DELAY_WIDTH    (DELAY_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> design/sspg_cfg_regs.sv
// APB-style configuration registers of the step/dir generator.
`default_nettype none
module sspg_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sspg_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [sspg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [sspg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output sspg_pkg::cfg_t                         cfg_o
);

  sspg_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        sspg_pkg::REG_STEP_DELAY:  cfg_d.step_delay = pwdata[sspg_pkg::STEP_DELAY_W-1:0];
        sspg_pkg::REG_HOME_DIR:    cfg_d.home_dir_high = pwdata[0];
        sspg_pkg::REG_REVERSE_DIR: cfg_d.reverse_direction = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sspg_pkg::REG_STEP_DELAY:
        prdata = sspg_pkg::APB_DATA_W'(cfg_q.step_delay);
      sspg_pkg::REG_HOME_DIR:
        prdata = sspg_pkg::APB_DATA_W'(cfg_q.home_dir_high);
      sspg_pkg::REG_REVERSE_DIR:
        prdata = sspg_pkg::APB_DATA_W'(cfg_q.reverse_direction);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_delay        <= sspg_pkg::STEP_DELAY_RST;
      cfg_q.home_dir_high     <= 1'b0;
      cfg_q.reverse_direction <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> design/sspg_core.sv
// Input register, position/step logic and result register of the step/dir generator.
`default_nettype none
module sspg_core #(
  parameter int unsigned POSITION_WIDTH = sspg_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned DELAY_WIDTH    = sspg_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sspg_pkg::cfg_t cfg_i,
  sspg_in_if.sink       in_ch,
  sspg_out_if.source    out_ch
);

  localparam int unsigned CMP_W =
    (DELAY_WIDTH > sspg_pkg::STEP_DELAY_W) ? DELAY_WIDTH : sspg_pkg::STEP_DELAY_W;

  // input register
  logic                                in_vld_q;
  sspg_pkg::op_e                       op_q;
  logic signed [sspg_pkg::VALUE_W-1:0] val_q;
  logic                                lim_q;

  // state
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [POSITION_WIDTH-1:0] tgt_q, tgt_d;
  logic                      mov_q, mov_d;
  logic                      dir_q, dir_d;
  logic [DELAY_WIDTH-1:0]    cnt_q, cnt_d;

  // result register
  logic                                out_vld_q;
  logic                                step_q, step_d;
  logic                                stop_q, stop_d;
  logic signed [sspg_pkg::VALUE_W-1:0] pos_out_q;
  logic                                dir_out_q, mov_out_q, on_tgt_q;

  logic                      adv;
  logic [POSITION_WIDTH-1:0] val_pos;
  logic [DELAY_WIDTH-1:0]    cnt_inc;
  logic                      due, up, lvl;

  assign adv         = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || adv;

  assign val_pos = POSITION_WIDTH'(val_q);
  assign cnt_inc = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign due     = CMP_W'(cnt_inc) >= CMP_W'(cfg_i.step_delay);
  assign up      = $signed(tgt_q) > $signed(pos_q);
  assign lvl     = (up ? ~cfg_i.home_dir_high : cfg_i.home_dir_high) ^ cfg_i.reverse_direction;

  always_comb begin
    pos_d  = pos_q;
    tgt_d  = tgt_q;
    mov_d  = mov_q;
    dir_d  = dir_q;
    cnt_d  = cnt_q;
    step_d = 1'b0;
    stop_d = 1'b0;
    case (op_q)
      sspg_pkg::OP_MOVE_ABS: begin
        tgt_d = val_pos;
        mov_d = 1'b1;
      end
      sspg_pkg::OP_MOVE_REL: begin
        tgt_d = pos_q + val_pos;
        mov_d = 1'b1;
      end
      sspg_pkg::OP_SET_POS: begin
        pos_d = val_pos;
        tgt_d = val_pos;
        mov_d = 1'b0;
      end
      default: begin
        cnt_d = cnt_inc;
        if (mov_q) begin
          if (pos_q == tgt_q) begin
            mov_d = 1'b0;
          end else if (due) begin
            if (lim_q && (lvl == cfg_i.home_dir_high)) begin
              mov_d  = 1'b0;
              tgt_d  = pos_q;
              stop_d = 1'b1;
            end else begin
              dir_d  = lvl;
              pos_d  = up ? pos_q + 1'b1 : pos_q - 1'b1;
              cnt_d  = '0;
              step_d = 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
      tgt_q     <= '0;
      mov_q     <= 1'b0;
      dir_q     <= 1'b0;
      cnt_q     <= '1;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        pos_q     <= pos_d;
        tgt_q     <= tgt_d;
        mov_q     <= mov_d;
        dir_q     <= dir_d;
        cnt_q     <= cnt_d;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      op_q  <= sspg_pkg::op_e'(in_ch.operation);
      val_q <= in_ch.value;
      lim_q <= in_ch.limit_active;
    end
    if (adv) begin
      step_q    <= step_d;
      stop_q    <= stop_d;
      dir_out_q <= dir_d;
      pos_out_q <= sspg_pkg::VALUE_W'(pos_d);
      mov_out_q <= mov_d;
      on_tgt_q  <= (pos_d == tgt_d);
    end
  end

  assign out_ch.valid           = out_vld_q;
  assign out_ch.step_issued     = step_q;
  assign out_ch.direction_level = dir_out_q;
  assign out_ch.position        = pos_out_q;
  assign out_ch.moving          = mov_out_q;
  assign out_ch.on_target       = on_tgt_q;
  assign out_ch.limit_stop      = stop_q;

endmodule
`default_nettype wire

>>> design/sspg_checker.sv
// Port-level checker of the step/dir generator and its bind to the top level.
`default_nettype none
module sspg_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                step_issued,
  input wire logic                                moving,
  input wire logic                                on_target,
  input wire logic                                limit_stop,
  input wire logic signed [sspg_pkg::VALUE_W-1:0] position
);

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(step_issued))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(step_issued && limit_stop))
    else $error("step and limit stop on one beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && limit_stop |-> !moving && on_target)
    else $error("limit stop left motion active");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && step_issued |-> moving)
    else $error("step issued while not moving");

endmodule

bind stepper_step_dir_position_generator_top sspg_checker u_sspg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .step_issued (out_ch.step_issued),
  .moving      (out_ch.moving),
  .on_target   (out_ch.on_target),
  .limit_stop  (out_ch.limit_stop),
  .position    (out_ch.position)
);
`default_nettype wire

>>> bench/tb.sv
// Testbench for the stepper step/dir position generator: random command and tick beats checked
`timescale 1ns / 1ps
module tb;
  import sspg_pkg::*;

  localparam int HOLD_AT  = 300;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE   = 6;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic                      limit;
  } motor_cmd_t;

  typedef struct packed {
    logic                      step;
    logic                      dir;
    logic signed [VALUE_W-1:0] position;
    logic                      moving;
    logic                      on_target;
    logic                      limit_stop;
  } motor_status_t;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sspg_in_if  in_ch ();
  sspg_out_if out_ch ();

  stepper_step_dir_position_generator_top u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  motor_cmd_t    cmd_backlog[$];
  motor_status_t predicted_status[$];

  logic [STEP_DELAY_W-1:0]   cfg_delay;
  logic                      cfg_home;
  logic                      cfg_rev;
  logic signed [VALUE_W-1:0] mtr_pos;
  logic signed [VALUE_W-1:0] mtr_target;
  logic                      mtr_moving;
  logic                      mtr_dir;
  logic [STEP_DELAY_W-1:0]   mtr_ticks;

  int            mismatches;
  int            queued_total;
  int            accepted_total;
  int            burst_left;
  int            gap_left;
  int            rdy_mode;
  int            rdy_mode_left;
  int            rdy_phase;
  int            hold_left;
  logic          hold_armed;
  logic          rdy;
  motor_status_t mon_want;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic motor_status_t advance_motor(motor_cmd_t c);
    motor_status_t r;
    logic          up;
    logic          lvl;
    r = '0;
    case (c.op)
      OP_MOVE_ABS: begin
        mtr_target = c.value;
        mtr_moving = 1'b1;
      end
      OP_MOVE_REL: begin
        mtr_target = mtr_pos + c.value;
        mtr_moving = 1'b1;
      end
      OP_SET_POS: begin
        mtr_pos    = c.value;
        mtr_target = c.value;
        mtr_moving = 1'b0;
      end
      default: begin
        if (mtr_ticks != '1) mtr_ticks = mtr_ticks + 1'b1;
        if (mtr_moving) begin
          if (mtr_pos == mtr_target) begin
            mtr_moving = 1'b0;
          end else if (mtr_ticks >= cfg_delay) begin
            up  = mtr_target > mtr_pos;
            lvl = (up ? ~cfg_home : cfg_home) ^ cfg_rev;
            if (c.limit && lvl == cfg_home) begin
              mtr_moving   = 1'b0;
              mtr_target   = mtr_pos;
              r.limit_stop = 1'b1;
            end else begin
              mtr_dir   = lvl;
              mtr_pos   = up ? mtr_pos + 1 : mtr_pos - 1;
              mtr_ticks = '0;
              r.step    = 1'b1;
            end
          end
        end
      end
    endcase
    r.dir       = mtr_dir;
    r.position  = mtr_pos;
    r.moving    = mtr_moving;
    r.on_target = (mtr_pos == mtr_target);
    return r;
  endfunction

  function automatic void queue_item(op_e op, logic [VALUE_W-1:0] value, logic limit);
    motor_cmd_t c;
    c.op    = op;
    c.value = value;
    c.limit = limit;
    cmd_backlog.push_back(c);
    queued_total++;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predicted_status.push_back(advance_motor(cmd_backlog.pop_front()));
        accepted_total <= accepted_total + 1;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= cmd_backlog[0].op;
        in_ch.value        <= cmd_backlog[0].value;
        in_ch.limit_active <= cmd_backlog[0].limit;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once the run is well under way
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && accepted_total >= HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: check each beat, stall on a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rdy_mode      = 0;
      rdy_mode_left = 0;
      rdy_phase     = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_status.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          mon_want = predicted_status.pop_front();
          check_field("step_issued", mon_want.step, out_ch.step_issued);
          check_field("direction_level", mon_want.dir, out_ch.direction_level);
          check_field("position", mon_want.position, out_ch.position);
          check_field("moving", mon_want.moving, out_ch.moving);
          check_field("on_target", mon_want.on_target, out_ch.on_target);
          check_field("limit_stop", mon_want.limit_stop, out_ch.limit_stop);
        end
      end
      if (rdy_mode_left == 0) begin
        rdy_mode      = $urandom_range(0, 3);
        rdy_mode_left = $urandom_range(8, 64);
      end else begin
        rdy_mode_left--;
      end
      rdy_phase++;
      case (rdy_mode)
        0:       rdy = 1'b1;
        1:       rdy = $urandom_range(0, 1);
        2:       rdy = (rdy_phase % 4 == 0);
        default: rdy = ($urandom_range(0, 9) != 0);
      endcase
      out_ch.ready <= rdy && (hold_left == 0);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STEP_DELAY:  cfg_delay = data[STEP_DELAY_W-1:0];
      REG_HOME_DIR:    cfg_home  = data[0];
      REG_REVERSE_DIR: cfg_rev   = data[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || predicted_status.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input int dly, input logic home, input logic rev);
    write_reg(REG_STEP_DELAY, dly);
    write_reg(REG_HOME_DIR, {31'd0, home});
    write_reg(REG_REVERSE_DIR, {31'd0, rev});
  endtask

  // one move followed by ticks, enough to arrive when the delay is at most 3, or a noise command
  task automatic push_motion(input int dly);
    int                        k;
    int                        n;
    int                        per_step;
    int                        lim_odds;
    logic signed [VALUE_W-1:0] x;
    logic signed [VALUE_W-1:0] d;
    k        = $urandom_range(0, 9);
    per_step = (dly > 3) ? 4 : dly + 1;
    lim_odds = 8;
    d        = $signed($urandom_range(0, 24)) - 12;
    if (k < 4) begin
      queue_item(OP_MOVE_REL, d, $urandom_range(0, 1));
    end else if (k < 7) begin
      x = ($urandom_range(0, 2) == 0) ? 32'h7FFF_FFF8 + $urandom_range(0, 15) : $urandom;
      queue_item(OP_SET_POS, x, $urandom_range(0, 1));
      queue_item(OP_MOVE_ABS, x + d, $urandom_range(0, 1));
    end else if (k < 8) begin
      queue_item(op_e'($urandom_range(1, 3)), $urandom, $urandom_range(0, 1));
    end else begin
      queue_item(OP_MOVE_REL, d, 1'b0);
      lim_odds = 2;
    end
    n = ((d < 0) ? -d : d) * per_step + $urandom_range(0, 4);
    repeat (n) queue_item(OP_TICK, $urandom, $urandom_range(0, lim_odds - 1) == 0);
  endtask

  task automatic run_phase(input int dly, input logic home, input logic rev, input int count);
    int start;
    set_config(dly, home, rev);
    start = queued_total;
    while (queued_total - start < count) push_motion(dly);
    drain();
  endtask

  initial begin
    clk     = 1'b0;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_TICK;
    in_ch.value        = '0;
    in_ch.limit_active = 1'b0;
    out_ch.ready       = 1'b0;
    mismatches     = 0;
    queued_total   = 0;
    accepted_total = 0;
    cfg_delay  = STEP_DELAY_RST;
    cfg_home   = 1'b0;
    cfg_rev    = 1'b0;
    mtr_pos    = '0;
    mtr_target = '0;
    mtr_moving = 1'b0;
    mtr_dir    = 1'b0;
    mtr_ticks  = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // saturated count after reset: first step immediate, then wait out the delay
    queue_item(OP_MOVE_ABS, 32'd3, 1'b1);
    queue_item(OP_TICK, 32'd0, 1'b0);
    queue_item(OP_TICK, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b0);
    drain();

    set_config(0, 1'b0, 1'b0);
    queue_item(OP_SET_POS, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_MOVE_REL, 32'd1, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b1);
    queue_item(OP_TICK, 32'd0, 1'b1);
    queue_item(OP_SET_POS, 32'h8000_0000, 1'b1);
    queue_item(OP_MOVE_ABS, 32'h7FFF_FFFF, 1'b1);
    queue_item(OP_TICK, 32'hFFFF_FFFF, 1'b1);
    queue_item(OP_MOVE_REL, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b0);
    queue_item(OP_MOVE_ABS, 32'h8000_0000, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b0);
    queue_item(OP_SET_POS, 32'd0, 1'b0);
    queue_item(OP_MOVE_REL, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b1);
    queue_item(OP_SET_POS, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_MOVE_REL, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b1);
    queue_item(OP_MOVE_REL, 32'h8000_0000, 1'b0);
    queue_item(OP_TICK, 32'd0, 1'b1);
    queue_item(OP_TICK, 32'd0, 1'b0);
    drain();

    run_phase(0, 1'b0, 1'b0, 120);
    run_phase(1, 1'b1, 1'b0, 120);
    run_phase(0, 1'b1, 1'b1, 120);
    run_phase(3, 1'b0, 1'b1, 110);
    run_phase($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1), 110);
    run_phase(65535, $urandom_range(0, 1), $urandom_range(0, 1), 50);
    run_phase($urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(0, 1), 120);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> stepper_step_dir_position_generator_top.f
design/sspg_pkg.sv
design/sspg_if.sv
design/sspg_cfg_regs.sv
design/sspg_core.sv
design/stepper_step_dir_position_generator_top.sv
design/sspg_checker.sv
bench/tb.sv
